FILE: design/sle_pkg.sv
`timescale 1ns / 1ps

package sle_pkg;

    // list geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 16;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // stream field widths
    localparam int CMD_W  = 3;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 16;
    localparam int STAT_W = 2;

    // compare width wide enough for position, count and count + 1
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam int IN_TDATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = CMD_W;
    localparam int OUT_FIELD_W = VAL_W + POS_W + STAT_W + POS_W + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

endpackage

FILE: design/sequential_list_engine_core.sv
`timescale 1ns / 1ps

// Channel    Dir  Ports                          Contents (low bit up)
// s_axis     in   tvalid/tready/tdata/tuser      tdata: position[4:0], value[20:5]
//                                                tuser: command[2:0]
// m_axis     out  tvalid/tready/tdata            tdata: result_value[15:0],
//                                                found_position[20:16], status[22:21],
//                                                list_length[27:23], is_empty[28]
//
// One command at a time. The list lives in a 1R1W RAM with registered read.
// Insert/delete walk the entries from the end / the position, one entry per
// cycle. Locate scans up to count entries, stopping at the first match.
// Synchronous active-low reset clears count and control; RAM contents are
// not cleared (entries at or past the count are never read).
// A result waiting on m_axis stalls only the end of the next command.

module sequential_list_engine_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [sle_pkg::IN_TDATA_W-1:0] s_axis_tdata,   // position, value
    input  logic [sle_pkg::IN_TUSER_W-1:0] s_axis_tuser,   // command
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sle_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // result_value, found_position,
                                                           // status, list_length, is_empty
);

    import sle_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,      // insert: shift tail up one slot
        ST_DOWN,    // delete: read victim, shift tail down
        ST_GET,
        ST_GETW,
        ST_SCAN,    // locate
        ST_FINISH
    } t_state;

    t_state r_state, n_state;

    logic [POS_W-1:0]       r_pos,   n_pos;
    logic [DATA_WIDTH-1:0]  r_val,   n_val;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_idx,   n_idx;     // next read index
    logic [CNT_W-1:0]       r_raddr, n_raddr;   // address of read in flight
    logic                   r_rpend, n_rpend;   // read data arrives this cycle
    logic [DATA_WIDTH-1:0]  r_res,   n_res;
    logic [POS_W-1:0]       r_found, n_found;
    logic [STAT_W-1:0]      r_stat,  n_stat;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data,  n_out_data;

    // RAM port
    logic                  ram_wr_en;
    logic [ADDR_W-1:0]     ram_wr_addr;
    logic [DATA_WIDTH-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [ADDR_W-1:0]     ram_rd_addr;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    // input fields
    logic [CMD_W-1:0] in_cmd;
    logic [POS_W-1:0] in_pos;
    logic [VAL_W-1:0] in_val;
    logic             in_xfer;

    logic [CMP_W-1:0] in_pos_x, cnt_x, pos_x, idx_x;
    logic [CNT_W-1:0] pos_m1;

    assign in_cmd  = s_axis_tuser[CMD_W-1:0];
    assign in_pos  = s_axis_tdata[POS_W-1:0];
    assign in_val  = s_axis_tdata[POS_W+VAL_W-1:POS_W];
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    assign in_pos_x = CMP_W'(in_pos);
    assign cnt_x    = CMP_W'(r_count);
    assign pos_x    = CMP_W'(r_pos);
    assign idx_x    = CMP_W'(r_idx);
    assign pos_m1   = CNT_W'(pos_x - CMP_W'(1));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    sle_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_val       = r_val;
        n_count     = r_count;
        n_idx       = r_idx;
        n_raddr     = r_raddr;
        n_rpend     = r_rpend;
        n_res       = r_res;
        n_found     = r_found;
        n_stat      = r_stat;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_pos   = in_pos;
                    n_val   = in_val[DATA_WIDTH-1:0];
                    n_res   = '0;
                    n_found = '0;
                    n_stat  = STAT_OK;
                    n_rpend = 1'b0;
                    n_state = ST_FINISH;
                    if (in_cmd == CMD_INSERT) begin
                        // full is checked before the position
                        if (cnt_x == CMP_W'(DEPTH)) begin
                            n_stat = STAT_FULL;
                        end else if (in_pos == '0 || in_pos_x > cnt_x + CMP_W'(1)) begin
                            n_stat = STAT_RANGE;
                        end else begin
                            n_idx   = r_count;
                            n_state = ST_UP;
                        end
                    end else if (in_cmd == CMD_DELETE || in_cmd == CMD_GET) begin
                        if (in_pos == '0 || in_pos_x > cnt_x) begin
                            n_stat = STAT_RANGE;
                        end else begin
                            n_idx   = CNT_W'(in_pos_x - CMP_W'(1));
                            n_state = (in_cmd == CMD_DELETE) ? ST_DOWN : ST_GET;
                        end
                    end else if (in_cmd == CMD_LOCATE) begin
                        n_stat  = STAT_NOTFOUND;
                        n_idx   = '0;
                        n_state = ST_SCAN;
                    end else if (in_cmd == CMD_CLEAR) begin
                        n_count = '0;
                    end
                end
            end

            ST_UP: begin
                // entry read last cycle moves one slot up
                if (r_rpend) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = ADDR_W'(r_raddr + CNT_W'(1));
                    ram_wr_data = ram_rd_data;
                end
                if (idx_x >= pos_x) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ADDR_W'(r_idx - CNT_W'(1));
                    n_raddr     = r_idx - CNT_W'(1);
                    n_rpend     = 1'b1;
                    n_idx       = r_idx - CNT_W'(1);
                end else if (r_rpend) begin
                    n_rpend = 1'b0;
                end else begin
                    // write port free: drop the new value in
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = ADDR_W'(pos_m1);
                    ram_wr_data = r_val;
                    n_count     = r_count + CNT_W'(1);
                    n_state     = ST_FINISH;
                end
            end

            ST_DOWN: begin
                // first read is the removed entry, the rest move down a slot
                if (r_rpend) begin
                    if (r_raddr == pos_m1) begin
                        n_res = ram_rd_data;
                    end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = ADDR_W'(r_raddr - CNT_W'(1));
                        ram_wr_data = ram_rd_data;
                    end
                end
                if (r_idx < r_count) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ADDR_W'(r_idx);
                    n_raddr     = r_idx;
                    n_rpend     = 1'b1;
                    n_idx       = r_idx + CNT_W'(1);
                end else if (r_rpend) begin
                    n_rpend = 1'b0;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = ST_FINISH;
                end
            end

            ST_GET: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = ADDR_W'(r_idx);
                n_state     = ST_GETW;
            end

            ST_GETW: begin
                n_res   = ram_rd_data;
                n_state = ST_FINISH;
            end

            ST_SCAN: begin
                if (r_rpend && ram_rd_data == r_val) begin
                    n_found = POS_W'(r_raddr + CNT_W'(1));
                    n_stat  = STAT_OK;
                    n_rpend = 1'b0;
                    n_state = ST_FINISH;
                end else if (r_idx < r_count) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ADDR_W'(r_idx);
                    n_raddr     = r_idx;
                    n_rpend     = 1'b1;
                    n_idx       = r_idx + CNT_W'(1);
                end else if (r_rpend) begin
                    n_rpend = 1'b0;
                end else begin
                    n_state = ST_FINISH;
                end
            end

            ST_FINISH: begin
                // load the result once the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_data = OUT_TDATA_W'({(r_count == '0),
                                               POS_W'(r_count),
                                               r_stat,
                                               r_found,
                                               VAL_W'(r_res)});
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rpend     <= n_rpend;
            r_out_valid <= n_out_valid;
        end
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_idx      <= n_idx;
        r_raddr    <= n_raddr;
        r_res      <= n_res;
        r_found    <= n_found;
        r_stat     <= n_stat;
        r_out_data <= n_out_data;
    end

endmodule

FILE: design/sle_ram.sv
`timescale 1ns / 1ps

module sle_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import sle_pkg::*;

    localparam int POS_MAX = (1 << POS_W) - 1;
    // highest command code; everything above CMD_CLEAR is a no-op
    localparam logic [CMD_W-1:0] CMD_TOP = '1;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [POS_W-1:0]  found;
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  length;
        logic              empty;
    } t_list_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // position, value
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;   // command
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // result_value, found_position,
                                                 // status, list_length, is_empty

    // shadow of the list held by the engine
    logic [VAL_W-1:0] list_words [DEPTH];
    int               list_len = 0;

    t_list_result pending_results [$];
    t_list_result next_result;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int sink_hold      = 0;   // forced receiver hold-off, in cycles

    int mismatch_count  = 0;
    int results_checked = 0;
    int commands_sent   = 0;
    int status_seen [4] = '{default: 0};

    sequential_list_engine_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Predict one command: updates the shadow list, returns the result word.
    function automatic t_list_result list_apply(input logic [CMD_W-1:0] cmd,
                                                input logic [POS_W-1:0] pos,
                                                input logic [VAL_W-1:0] val);
        t_list_result r;
        int           p;
        int           k;
        bit           hit;
        r        = '0;
        r.status = STAT_OK;
        p        = int'(pos);
        hit      = 1'b0;
        case (cmd)
            CMD_INSERT: begin
                // full list is checked ahead of the position
                if (list_len >= DEPTH) begin
                    r.status = STAT_FULL;
                end else if (p < 1 || p > list_len + 1) begin
                    r.status = STAT_RANGE;
                end else begin
                    for (k = list_len; k >= p; k--)
                        list_words[k] = list_words[k-1];
                    list_words[p-1] = val;
                    list_len++;
                end
            end
            CMD_DELETE: begin
                if (p < 1 || p > list_len) begin
                    r.status = STAT_RANGE;
                end else begin
                    r.value = list_words[p-1];
                    for (k = p - 1; k + 1 < list_len; k++)
                        list_words[k] = list_words[k+1];
                    list_len--;
                end
            end
            CMD_GET: begin
                if (p < 1 || p > list_len)
                    r.status = STAT_RANGE;
                else
                    r.value = list_words[p-1];
            end
            CMD_LOCATE: begin
                r.status = STAT_NOTFOUND;
                for (k = 0; k < list_len; k++) begin
                    if (!hit && list_words[k] == val) begin
                        hit      = 1'b1;
                        r.found  = POS_W'(k + 1);
                        r.status = STAT_OK;
                    end
                end
            end
            CMD_CLEAR: begin
                list_len = 0;   // words stay, only the length drops
            end
            default: ;          // unused codes do nothing
        endcase
        r.length = POS_W'(list_len);
        r.empty  = (list_len == 0);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch at result %0d: %s = %0h, expected %0h",
                     results_checked, what, got, want);
    endtask

    // One command transfer; the expected result is queued at the accepting edge.
    task automatic push_command(input logic [CMD_W-1:0] cmd,
                                input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val);
        int           gap;
        t_list_result r;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(IN_TDATA_W - POS_W - VAL_W){1'b0}}, val, pos};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        r = list_apply(cmd, pos, val);
        pending_results.push_back(r);
        commands_sent++;
        status_seen[r.status]++;
    endtask

    // Drop valid and hold off until every queued result has come back.
    task automatic wait_results_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly well-formed commands against the current list, plus some noise.
    task automatic issue_random_command();
        int               pick;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        pick = $urandom_range(99);
        // small values give duplicates, so locate has to find the first one
        val  = $urandom_range(1) ? VAL_W'($urandom_range(7))
                                 : VAL_W'($urandom_range(16'hFFFF));
        pos  = POS_W'($urandom_range(POS_MAX));
        if (pick < 36) begin
            cmd = CMD_INSERT;
            if ($urandom_range(9) < 8)
                pos = POS_W'($urandom_range(1, list_len + 1));
        end else if (pick < 56) begin
            cmd = CMD_DELETE;
            if (list_len > 0 && $urandom_range(9) < 8)
                pos = POS_W'($urandom_range(1, list_len));
        end else if (pick < 70) begin
            cmd = CMD_GET;
            if (list_len > 0 && $urandom_range(9) < 8)
                pos = POS_W'($urandom_range(1, list_len));
        end else if (pick < 85) begin
            cmd = CMD_LOCATE;
            if (list_len > 0 && $urandom_range(9) < 7)
                val = list_words[$urandom_range(0, list_len - 1)];
        end else if (pick < 88) begin
            cmd = CMD_CLEAR;
        end else if (pick < 92) begin
            cmd = CMD_W'($urandom_range(int'(CMD_CLEAR) + 1, int'(CMD_TOP)));
        end else begin
            cmd = CMD_W'($urandom_range(int'(CMD_TOP)));
        end
        push_command(cmd, pos, val);
    endtask

    // Edge positions, every command, empty-list cases, unused codes.
    task automatic test_directed();
        push_command(CMD_GET,    5'd1,  16'h0000);    // get on empty list
        push_command(CMD_DELETE, 5'd0,  16'h0000);    // position zero
        push_command(CMD_LOCATE, 5'd0,  16'hFFFF);    // search on empty list
        push_command(CMD_INSERT, 5'd0,  16'hAAAA);    // position zero
        push_command(CMD_INSERT, 5'd2,  16'h5555);    // past length + 1
        push_command(CMD_INSERT, 5'd1,  16'hFFFF);
        push_command(CMD_INSERT, 5'd1,  16'h0000);    // in front
        push_command(CMD_INSERT, 5'd3,  16'h1234);    // append
        push_command(CMD_INSERT, 5'd2,  16'h8001);    // middle
        push_command(CMD_GET,    5'd0,  16'h0000);
        push_command(CMD_GET,    5'd4,  16'h0000);
        push_command(CMD_GET,    5'd5,  16'h0000);    // one past the end
        push_command(CMD_LOCATE, 5'd0,  16'hFFFF);
        push_command(CMD_LOCATE, 5'd31, 16'h5555);    // no match
        push_command(CMD_DELETE, 5'd2,  16'h0000);
        push_command(CMD_DELETE, 5'd3,  16'h0000);    // last entry
        push_command(CMD_DELETE, 5'd31, 16'hFFFF);
        push_command(CMD_CLEAR + 1'b1, 5'd31, 16'hFFFF);
        push_command(CMD_TOP,    5'd16, 16'h8000);
        push_command(CMD_CLEAR,  5'd31, 16'hFFFF);
        push_command(CMD_GET,    5'd1,  16'h0000);    // after clear
        push_command(CMD_LOCATE, 5'd1,  16'h0000);    // stale word must not match
        wait_results_drained();
    endtask

    // Fill to the top, poke the full list, then empty it again.
    task automatic test_fill_and_drain();
        int k;
        push_command(CMD_CLEAR, POS_W'($urandom_range(POS_MAX)), 16'h0000);
        for (k = 0; k < DEPTH; k++)
            push_command(CMD_INSERT, POS_W'($urandom_range(1, list_len + 1)),
                         VAL_W'($urandom_range(16'hFFFF)));
        push_command(CMD_INSERT, 5'd0,  16'h1111);    // full wins over bad position
        push_command(CMD_INSERT, 5'd17, 16'h2222);
        push_command(CMD_INSERT, 5'd1,  16'h3333);
        push_command(CMD_GET,    5'd16, 16'h0000);
        push_command(CMD_GET,    5'd17, 16'h0000);
        push_command(CMD_LOCATE, 5'd0,  list_words[DEPTH-1]);
        push_command(CMD_DELETE, 5'd16, 16'h0000);
        push_command(CMD_DELETE, 5'd1,  16'h0000);
        push_command(CMD_DELETE, 5'd0,  16'h0000);
        while (list_len > 0)
            push_command(CMD_DELETE, POS_W'($urandom_range(1, list_len)), 16'h0000);
        push_command(CMD_DELETE, 5'd1, 16'h0000);
        wait_results_drained();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int count);
        int n;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        for (n = 0; n < count; n++)
            issue_random_command();
        wait_results_drained();
    endtask

    // Receiver blocks for a long stretch while commands keep coming,
    // so the engine backs up and drops s_axis_tready.
    task automatic test_backpressure();
        int n;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        @(negedge i_clk);
        sink_hold = 300;
        for (n = 0; n < 16; n++)
            issue_random_command();
        wait_results_drained();
    endtask

    // receiver side: random stalls plus the forced hold-off
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold = sink_hold - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result word", int'(m_axis_tdata), 0);
            end else begin
                next_result = pending_results.pop_front();
                if (m_axis_tdata[15:0] != next_result.value)
                    flag_mismatch("result_value", int'(m_axis_tdata[15:0]),
                                  int'(next_result.value));
                if (m_axis_tdata[20:16] != next_result.found)
                    flag_mismatch("found_position", int'(m_axis_tdata[20:16]),
                                  int'(next_result.found));
                if (m_axis_tdata[22:21] != next_result.status)
                    flag_mismatch("status", int'(m_axis_tdata[22:21]),
                                  int'(next_result.status));
                if (m_axis_tdata[27:23] != next_result.length)
                    flag_mismatch("list_length", int'(m_axis_tdata[27:23]),
                                  int'(next_result.length));
                if (m_axis_tdata[28] != next_result.empty)
                    flag_mismatch("is_empty", int'(m_axis_tdata[28]),
                                  int'(next_result.empty));
            end
            results_checked++;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_fill_and_drain();
        test_random_phase(0, 0, 260);
        test_backpressure();
        test_random_phase(54, 0, 250);
        test_fill_and_drain();
        test_random_phase(0, 54, 250);
        test_random_phase(29, 29, 250);

        repeat (40) @(posedge i_clk);
        $display("run: %0d commands, %0d results; ok %0d, range %0d, full %0d, not found %0d",
                 commands_sent, results_checked, status_seen[STAT_OK],
                 status_seen[STAT_RANGE], status_seen[STAT_FULL],
                 status_seen[STAT_NOTFOUND]);
        $display("run: idle/stall mixes, long receiver hold-off, two fill-to-full passes");
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
